// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL; xcsb_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define XCSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define XCSB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/xcsb_pkg.sv =====
// Package: types, request codes and defaults for the cut signature bridge unit.
package xcsb_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned MAX_EDGES = 4096;
  localparam int unsigned LABEL_W   = 128;

  localparam logic [2:0] REQ_LOAD_NODE = 3'd0;
  localparam logic [2:0] REQ_LOAD_EDGE = 3'd1;
  localparam logic [2:0] REQ_COMPUTE   = 3'd2;
  localparam logic [2:0] REQ_READ      = 3'd3;
  localparam logic [2:0] REQ_CLEAR     = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  node_id;
    logic [9:0]  parent_node;
    logic [11:0] link_edge;
    logic [11:0] edge_id;
    logic [9:0]  end_a;
    logic [9:0]  end_b;
    logic [63:0] label_high;
    logic [63:0] label_low;
  } req_t;

  typedef struct packed {
    logic [11:0] result_edge;
    logic [63:0] sig_high;
    logic [63:0] sig_low;
    logic        tree_flag;
    logic        bridge_flag;
  } res_t;

  typedef struct packed {
    logic order;
    logic info;
    logic acc;
  } node_we_t;

  typedef struct packed {
    logic info;
    logic sig;
    logic tree;
  } edge_we_t;

endpackage

// ===== hw/rtl/xcsb_node_mem.sv =====
// Node-side memories: BFS order list, parent tables and XOR accumulators.
module xcsb_node_mem #(
  parameter int unsigned MaxNodes = xcsb_pkg::MAX_NODES,
  localparam int unsigned NW = $clog2(MaxNodes)
) (
  input  logic                         clk_i,
  input  xcsb_pkg::node_we_t           we_i,
  input  logic [NW-1:0]                order_waddr_i,
  input  logic [NW-1:0]                order_wdata_i,
  input  logic [NW-1:0]                order_raddr_i,
  output logic [NW-1:0]                order_rdata_o,
  input  logic [NW-1:0]                info_waddr_i,
  input  logic [NW-1:0]                parent_wdata_i,
  input  logic [11:0]                  pedge_wdata_i,
  input  logic [NW-1:0]                info_raddr_i,
  output logic [NW-1:0]                parent_rdata_o,
  output logic [11:0]                  pedge_rdata_o,
  input  logic [NW-1:0]                acc_waddr_i,
  input  logic [xcsb_pkg::LABEL_W-1:0] acc_wdata_i,
  input  logic [NW-1:0]                acc_raddr_i,
  output logic [xcsb_pkg::LABEL_W-1:0] acc_rdata_o
);

  logic [NW-1:0]                order_mem  [MaxNodes];
  logic [NW-1:0]                parent_mem [MaxNodes];
  logic [11:0]                  pedge_mem  [MaxNodes];
  logic [xcsb_pkg::LABEL_W-1:0] acc_mem    [MaxNodes];

  always_ff @(posedge clk_i) begin
    if (we_i.order) begin
      order_mem[order_waddr_i] <= order_wdata_i;
    end
    order_rdata_o <= order_mem[order_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.info) begin
      parent_mem[info_waddr_i] <= parent_wdata_i;
      pedge_mem[info_waddr_i]  <= pedge_wdata_i;
    end
    parent_rdata_o <= parent_mem[info_raddr_i];
    pedge_rdata_o  <= pedge_mem[info_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.acc) begin
      acc_mem[acc_waddr_i] <= acc_wdata_i;
    end
    acc_rdata_o <= acc_mem[acc_raddr_i];
  end

endmodule

// ===== hw/rtl/xcsb_edge_mem.sv =====
// Edge-side memories: endpoints, labels, signatures and tree marks.
module xcsb_edge_mem #(
  parameter int unsigned MaxNodes = xcsb_pkg::MAX_NODES,
  parameter int unsigned MaxEdges = xcsb_pkg::MAX_EDGES,
  localparam int unsigned NW = $clog2(MaxNodes),
  localparam int unsigned EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1
) (
  input  logic                         clk_i,
  input  xcsb_pkg::edge_we_t           we_i,
  input  logic [EW-1:0]                waddr_i,
  input  logic [EW-1:0]                raddr_i,
  input  logic [NW-1:0]                end_a_wdata_i,
  input  logic [NW-1:0]                end_b_wdata_i,
  input  logic [xcsb_pkg::LABEL_W-1:0] label_wdata_i,
  input  logic [xcsb_pkg::LABEL_W-1:0] sig_wdata_i,
  input  logic                         tree_wdata_i,
  output logic [NW-1:0]                end_a_rdata_o,
  output logic [NW-1:0]                end_b_rdata_o,
  output logic [xcsb_pkg::LABEL_W-1:0] label_rdata_o,
  output logic [xcsb_pkg::LABEL_W-1:0] sig_rdata_o,
  output logic                         tree_rdata_o
);

  logic [NW-1:0]                end_a_mem [MaxEdges];
  logic [NW-1:0]                end_b_mem [MaxEdges];
  logic [xcsb_pkg::LABEL_W-1:0] label_mem [MaxEdges];
  logic [xcsb_pkg::LABEL_W-1:0] sig_mem   [MaxEdges];
  logic                         tree_mem  [MaxEdges];

  always_ff @(posedge clk_i) begin
    if (we_i.info) begin
      end_a_mem[waddr_i] <= end_a_wdata_i;
      end_b_mem[waddr_i] <= end_b_wdata_i;
      label_mem[waddr_i] <= label_wdata_i;
    end
    end_a_rdata_o <= end_a_mem[raddr_i];
    end_b_rdata_o <= end_b_mem[raddr_i];
    label_rdata_o <= label_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.sig) begin
      sig_mem[waddr_i] <= sig_wdata_i;
    end
    sig_rdata_o <= sig_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.tree) begin
      tree_mem[waddr_i] <= tree_wdata_i;
    end
    tree_rdata_o <= tree_mem[raddr_i];
  end

endmodule

// ===== hw/rtl/xcsb_ctrl.sv =====
// Sequencer: loads, clearing sweep, mark / edge / reverse-walk passes and reads.
`include "assert_macros.svh"
module xcsb_ctrl #(
  parameter int unsigned MaxNodes = xcsb_pkg::MAX_NODES,
  parameter int unsigned MaxEdges = xcsb_pkg::MAX_EDGES,
  localparam int unsigned NW = $clog2(MaxNodes),
  localparam int unsigned EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  xcsb_pkg::req_t               req_i,
  output logic                         result_valid_o,
  output xcsb_pkg::res_t               result_o,
  // node memory
  output xcsb_pkg::node_we_t           nwe_o,
  output logic [NW-1:0]                order_waddr_o,
  output logic [NW-1:0]                order_wdata_o,
  output logic [NW-1:0]                order_raddr_o,
  input  logic [NW-1:0]                order_rdata_i,
  output logic [NW-1:0]                info_waddr_o,
  output logic [NW-1:0]                parent_wdata_o,
  output logic [11:0]                  pedge_wdata_o,
  output logic [NW-1:0]                info_raddr_o,
  input  logic [NW-1:0]                parent_rdata_i,
  input  logic [11:0]                  pedge_rdata_i,
  output logic [NW-1:0]                acc_waddr_o,
  output logic [xcsb_pkg::LABEL_W-1:0] acc_wdata_o,
  output logic [NW-1:0]                acc_raddr_o,
  input  logic [xcsb_pkg::LABEL_W-1:0] acc_rdata_i,
  // edge memory
  output xcsb_pkg::edge_we_t           ewe_o,
  output logic [EW-1:0]                e_waddr_o,
  output logic [EW-1:0]                e_raddr_o,
  output logic [NW-1:0]                end_a_wdata_o,
  output logic [NW-1:0]                end_b_wdata_o,
  output logic [xcsb_pkg::LABEL_W-1:0] label_wdata_o,
  output logic [xcsb_pkg::LABEL_W-1:0] sig_wdata_o,
  output logic                         tree_wdata_o,
  input  logic [NW-1:0]                end_a_rdata_i,
  input  logic [NW-1:0]                end_b_rdata_i,
  input  logic [xcsb_pkg::LABEL_W-1:0] label_rdata_i,
  input  logic [xcsb_pkg::LABEL_W-1:0] sig_rdata_i,
  input  logic                         tree_rdata_i
);

  localparam int unsigned SDepth = (MaxNodes > MaxEdges) ? MaxNodes : MaxEdges;
  localparam int unsigned SW     = $clog2(SDepth);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_M0    = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_M2    = 4'd4;
  localparam logic [3:0] S_E0    = 4'd5;
  localparam logic [3:0] S_E1    = 4'd6;
  localparam logic [3:0] S_E2    = 4'd7;
  localparam logic [3:0] S_E3    = 4'd8;
  localparam logic [3:0] S_W0    = 4'd9;
  localparam logic [3:0] S_W1    = 4'd10;
  localparam logic [3:0] S_W2    = 4'd11;
  localparam logic [3:0] S_W3    = 4'd12;

  logic [3:0]                   state_q, state_d;
  logic [SW-1:0]                sweep_q, sweep_d;
  logic                         cmp_q, cmp_d;
  logic [NW:0]                  ncnt_q, ncnt_d;
  logic [EW:0]                  ecnt_q, ecnt_d;
  logic [NW:0]                  k_q, k_d;
  logic [EW:0]                  e_q, e_d;
  logic [NW-1:0]                v_q, v_d;
  logic [NW-1:0]                a_q, a_d;
  logic [NW-1:0]                b_q, b_d;
  logic [xcsb_pkg::LABEL_W-1:0] val_q, val_d;
  logic                         rv_q, rv_d;
  logic                         oor_q, oor_d;
  logic [11:0]                  redge_q, redge_d;

  logic accept;
  logic node_ok, edge_ok, pe_ok, pe_ok_m;
  logic [EW:0] eid_ext;
  logic [xcsb_pkg::LABEL_W-1:0] sig_out;

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign node_ok = (ncnt_q < (NW+1)'(MaxNodes)) && (32'(req_i.node_id) < MaxNodes)
                   && (32'(req_i.parent_node) < MaxNodes);
  assign edge_ok = (32'(req_i.edge_id) < MaxEdges) && (32'(req_i.end_a) < MaxNodes)
                   && (32'(req_i.end_b) < MaxNodes);
  assign eid_ext = (EW+1)'(req_i.edge_id) + (EW+1)'(1);
  assign pe_ok   = 32'(pedge_rdata_i) < 32'(ecnt_q);
  assign pe_ok_m = pe_ok && (parent_rdata_i != v_q);

  assign sig_out = oor_q ? '0 : sig_rdata_i;
  assign result_valid_o       = rv_q;
  assign result_o.result_edge = redge_q;
  assign result_o.sig_high    = sig_out[127:64];
  assign result_o.sig_low     = sig_out[63:0];
  assign result_o.tree_flag   = tree_rdata_i && !oor_q;
  assign result_o.bridge_flag = tree_rdata_i && !oor_q && (sig_out == '0);

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    cmp_d   = cmp_q;
    ncnt_d  = ncnt_q;
    ecnt_d  = ecnt_q;
    k_d     = k_q;
    e_d     = e_q;
    v_d     = v_q;
    a_d     = a_q;
    b_d     = b_q;
    val_d   = val_q;
    rv_d    = 1'b0;
    oor_d   = oor_q;
    redge_d = redge_q;

    nwe_o          = '0;
    order_waddr_o  = NW'(ncnt_q);
    order_wdata_o  = NW'(req_i.node_id);
    order_raddr_o  = NW'(k_q);
    info_waddr_o   = NW'(req_i.node_id);
    parent_wdata_o = NW'(req_i.parent_node);
    pedge_wdata_o  = req_i.link_edge;
    info_raddr_o   = order_rdata_i;
    acc_waddr_o    = NW'(sweep_q);
    acc_wdata_o    = '0;
    acc_raddr_o    = order_rdata_i;
    ewe_o          = '0;
    e_waddr_o      = EW'(req_i.edge_id);
    e_raddr_o      = EW'(req_i.edge_id);
    end_a_wdata_o  = NW'(req_i.end_a);
    end_b_wdata_o  = NW'(req_i.end_b);
    label_wdata_o  = {req_i.label_high, req_i.label_low};
    sig_wdata_o    = '0;
    tree_wdata_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            xcsb_pkg::REQ_LOAD_NODE: begin
              if (node_ok) begin
                nwe_o.order = 1'b1;
                nwe_o.info  = 1'b1;
                ncnt_d      = ncnt_q + (NW+1)'(1);
              end
            end
            xcsb_pkg::REQ_LOAD_EDGE: begin
              if (edge_ok) begin
                ewe_o.info = 1'b1;
                if (eid_ext > ecnt_q) ecnt_d = eid_ext;
              end
            end
            xcsb_pkg::REQ_COMPUTE: begin
              state_d = S_SWEEP;
              sweep_d = '0;
              cmp_d   = 1'b1;
            end
            xcsb_pkg::REQ_READ: begin
              rv_d    = 1'b1;
              oor_d   = !(32'(req_i.edge_id) < MaxEdges);
              redge_d = req_i.edge_id;
            end
            xcsb_pkg::REQ_CLEAR: begin
              state_d = S_SWEEP;
              sweep_d = '0;
              cmp_d   = 1'b0;
              ncnt_d  = '0;
              ecnt_d  = '0;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        if (32'(sweep_q) < MaxNodes) nwe_o.acc = 1'b1;
        if (32'(sweep_q) < MaxEdges) begin
          ewe_o.sig  = 1'b1;
          ewe_o.tree = 1'b1;
        end
        e_waddr_o = EW'(sweep_q);
        sweep_d   = sweep_q + SW'(1);
        if (32'(sweep_q) == SDepth - 1) begin
          k_d = '0;
          e_d = '0;
          if (!cmp_q) state_d = S_IDLE;
          else if (ncnt_q != '0) state_d = S_M0;
          else if (ecnt_q != '0) state_d = S_E0;
          else state_d = S_IDLE;
        end
      end
      S_M0: state_d = S_M1;
      S_M1: begin
        v_d     = order_rdata_i;
        state_d = S_M2;
      end
      S_M2: begin
        e_waddr_o    = EW'(pedge_rdata_i);
        tree_wdata_o = 1'b1;
        ewe_o.tree   = pe_ok_m;
        k_d          = k_q + (NW+1)'(1);
        if (k_d == ncnt_q) begin
          e_d     = '0;
          state_d = (ecnt_q != '0) ? S_E0 : S_W0;
          k_d     = ncnt_q;
        end else begin
          state_d = S_M0;
        end
      end
      S_E0: begin
        e_raddr_o = EW'(e_q);
        state_d   = S_E1;
      end
      S_E1: begin
        a_d   = end_a_rdata_i;
        b_d   = end_b_rdata_i;
        val_d = label_rdata_i;
        if (tree_rdata_i || (end_a_rdata_i == end_b_rdata_i)) begin
          e_d = e_q + (EW+1)'(1);
          if (e_d == ecnt_q) begin
            k_d     = ncnt_q;
            state_d = (ncnt_q != '0) ? S_W0 : S_IDLE;
          end else begin
            state_d = S_E0;
          end
        end else begin
          e_waddr_o   = EW'(e_q);
          sig_wdata_o = label_rdata_i;
          ewe_o.sig   = 1'b1;
          acc_raddr_o = end_a_rdata_i;
          state_d     = S_E2;
        end
      end
      S_E2: begin
        acc_waddr_o = a_q;
        acc_wdata_o = acc_rdata_i ^ val_q;
        nwe_o.acc   = 1'b1;
        acc_raddr_o = b_q;
        state_d     = S_E3;
      end
      S_E3: begin
        acc_waddr_o = b_q;
        acc_wdata_o = acc_rdata_i ^ val_q;
        nwe_o.acc   = 1'b1;
        e_d         = e_q + (EW+1)'(1);
        if (e_d == ecnt_q) begin
          k_d     = ncnt_q;
          state_d = (ncnt_q != '0) ? S_W0 : S_IDLE;
        end else begin
          state_d = S_E0;
        end
      end
      S_W0: begin
        order_raddr_o = NW'(k_q - (NW+1)'(1));
        state_d       = S_W1;
      end
      S_W1: begin
        v_d     = order_rdata_i;
        state_d = S_W2;
      end
      S_W2: begin
        val_d = acc_rdata_i;
        a_d   = parent_rdata_i;
        if (parent_rdata_i == v_q) begin
          k_d     = k_q - (NW+1)'(1);
          state_d = (k_q == (NW+1)'(1)) ? S_IDLE : S_W0;
        end else begin
          e_waddr_o   = EW'(pedge_rdata_i);
          sig_wdata_o = acc_rdata_i;
          ewe_o.sig   = pe_ok;
          acc_raddr_o = parent_rdata_i;
          state_d     = S_W3;
        end
      end
      S_W3: begin
        acc_waddr_o = a_q;
        acc_wdata_o = acc_rdata_i ^ val_q;
        nwe_o.acc   = 1'b1;
        k_d         = k_q - (NW+1)'(1);
        state_d     = (k_q == (NW+1)'(1)) ? S_IDLE : S_W0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      cmp_q   <= 1'b0;
      ncnt_q  <= '0;
      ecnt_q  <= '0;
      k_q     <= '0;
      e_q     <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      cmp_q   <= cmp_d;
      ncnt_q  <= ncnt_d;
      ecnt_q  <= ecnt_d;
      k_q     <= k_d;
      e_q     <= e_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    a_q     <= a_d;
    b_q     <= b_d;
    val_q   <= val_d;
    oor_q   <= oor_d;
    redge_q <= redge_d;
  end

  `XCSB_ASSERT(a_res_after_read, rv_q |-> $past(accept && req_i.req_type == xcsb_pkg::REQ_READ),
               "result without a read transfer")
  `XCSB_NEVER(a_ncnt_range, ncnt_q > (NW+1)'(MaxNodes), "node count beyond depth")
  `XCSB_NEVER(a_ecnt_range, 32'(ecnt_q) > MaxEdges, "edge count beyond depth")
  `XCSB_NEVER(a_walk_k, (state_q == S_W0 || state_q == S_W3) && k_q == '0,
              "reverse walk with empty index")

endmodule

// ===== hw/rtl/xor_cut_signature_bridges_unit.sv =====
// Top level of the XOR cut signature bridge unit.
// Load, read and unknown requests keep busy low; a read strobes its result for one
// cycle after the transfer (no stall from the receiver) and the next request may go in then.
// Compute (one memory port per pass): clearing sweep of max(MAX_NODES, MAX_EDGES) addresses,
// marking (M0-M2), edges (E0-E1, E2-E3 unless tree or loop), reverse walk (W0-W2, W3 for non-roots).
// Reset and clear both run the clearing sweep; busy is high throughout it.
module xor_cut_signature_bridges_unit #(
  parameter int unsigned MaxNodes = xcsb_pkg::MAX_NODES,
  parameter int unsigned MaxEdges = xcsb_pkg::MAX_EDGES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  xcsb_pkg::req_t req_i,
  output logic           result_valid_o,
  output xcsb_pkg::res_t result_o
);

  localparam int unsigned NW = $clog2(MaxNodes);
  localparam int unsigned EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;

  xcsb_pkg::node_we_t           nwe;
  xcsb_pkg::edge_we_t           ewe;
  logic [NW-1:0]                order_waddr, order_wdata, order_raddr, order_rdata;
  logic [NW-1:0]                info_waddr, parent_wdata, info_raddr, parent_rdata;
  logic [11:0]                  pedge_wdata, pedge_rdata;
  logic [NW-1:0]                acc_waddr, acc_raddr;
  logic [xcsb_pkg::LABEL_W-1:0] acc_wdata, acc_rdata;
  logic [EW-1:0]                e_waddr, e_raddr;
  logic [NW-1:0]                end_a_wdata, end_b_wdata, end_a_rdata, end_b_rdata;
  logic [xcsb_pkg::LABEL_W-1:0] label_wdata, label_rdata, sig_wdata, sig_rdata;
  logic                         tree_wdata, tree_rdata;

  xcsb_ctrl #(.MaxNodes(MaxNodes), .MaxEdges(MaxEdges)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .busy_o(busy), .req_i, .result_valid_o, .result_o,
    .nwe_o(nwe), .order_waddr_o(order_waddr), .order_wdata_o(order_wdata),
    .order_raddr_o(order_raddr), .order_rdata_i(order_rdata),
    .info_waddr_o(info_waddr), .parent_wdata_o(parent_wdata), .pedge_wdata_o(pedge_wdata),
    .info_raddr_o(info_raddr), .parent_rdata_i(parent_rdata), .pedge_rdata_i(pedge_rdata),
    .acc_waddr_o(acc_waddr), .acc_wdata_o(acc_wdata), .acc_raddr_o(acc_raddr),
    .acc_rdata_i(acc_rdata),
    .ewe_o(ewe), .e_waddr_o(e_waddr), .e_raddr_o(e_raddr),
    .end_a_wdata_o(end_a_wdata), .end_b_wdata_o(end_b_wdata), .label_wdata_o(label_wdata),
    .sig_wdata_o(sig_wdata), .tree_wdata_o(tree_wdata),
    .end_a_rdata_i(end_a_rdata), .end_b_rdata_i(end_b_rdata), .label_rdata_i(label_rdata),
    .sig_rdata_i(sig_rdata), .tree_rdata_i(tree_rdata)
  );

  xcsb_node_mem #(.MaxNodes(MaxNodes)) u_node_mem (
    .clk_i, .we_i(nwe),
    .order_waddr_i(order_waddr), .order_wdata_i(order_wdata),
    .order_raddr_i(order_raddr), .order_rdata_o(order_rdata),
    .info_waddr_i(info_waddr), .parent_wdata_i(parent_wdata), .pedge_wdata_i(pedge_wdata),
    .info_raddr_i(info_raddr), .parent_rdata_o(parent_rdata), .pedge_rdata_o(pedge_rdata),
    .acc_waddr_i(acc_waddr), .acc_wdata_i(acc_wdata), .acc_raddr_i(acc_raddr),
    .acc_rdata_o(acc_rdata)
  );

  xcsb_edge_mem #(.MaxNodes(MaxNodes), .MaxEdges(MaxEdges)) u_edge_mem (
    .clk_i, .we_i(ewe), .waddr_i(e_waddr), .raddr_i(e_raddr),
    .end_a_wdata_i(end_a_wdata), .end_b_wdata_i(end_b_wdata), .label_wdata_i(label_wdata),
    .sig_wdata_i(sig_wdata), .tree_wdata_i(tree_wdata),
    .end_a_rdata_o(end_a_rdata), .end_b_rdata_o(end_b_rdata), .label_rdata_o(label_rdata),
    .sig_rdata_o(sig_rdata), .tree_rdata_o(tree_rdata)
  );

endmodule

// ===== tb/xcsb_checker.sv =====
// Checker for the cut signature bridge unit: predicts read results and compares them.
`timescale 1ns / 1ps
module xcsb_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  xcsb_pkg::req_t req_i,
  input  logic           result_valid_i,
  input  xcsb_pkg::res_t result_i,
  output int             fail_count_o,
  output int             pending_o
);

  logic [9:0]     visit_seq [xcsb_pkg::MAX_NODES];
  logic [9:0]     node_parent [xcsb_pkg::MAX_NODES];
  logic [11:0]    node_link [xcsb_pkg::MAX_NODES];
  logic [9:0]     edge_end_a [xcsb_pkg::MAX_EDGES];
  logic [9:0]     edge_end_b [xcsb_pkg::MAX_EDGES];
  logic [63:0]    label_hi [xcsb_pkg::MAX_EDGES];
  logic [63:0]    label_lo [xcsb_pkg::MAX_EDGES];
  logic           tree_edge [xcsb_pkg::MAX_EDGES];
  logic [63:0]    sig_hi [xcsb_pkg::MAX_EDGES];
  logic [63:0]    sig_lo [xcsb_pkg::MAX_EDGES];
  logic [63:0]    acc_hi [xcsb_pkg::MAX_NODES];
  logic [63:0]    acc_lo [xcsb_pkg::MAX_NODES];
  int unsigned    nodes_held;
  int unsigned    edges_held;
  xcsb_pkg::res_t read_results [$];

  function automatic void wipe_signatures();
    for (int e = 0; e < xcsb_pkg::MAX_EDGES; e++) begin
      tree_edge[e] = 1'b0;
      sig_hi[e] = '0;
      sig_lo[e] = '0;
    end
    for (int v = 0; v < xcsb_pkg::MAX_NODES; v++) begin
      acc_hi[v] = '0;
      acc_lo[v] = '0;
    end
  endfunction

  function automatic void compute_signatures();
    logic [9:0] v, p, a, b;
    logic [11:0] pe;
    wipe_signatures();
    for (int k = 0; k < nodes_held; k++) begin
      v = visit_seq[k];
      pe = node_link[v];
      if (node_parent[v] != v && pe < edges_held) tree_edge[pe] = 1'b1;
    end
    for (int e = 0; e < edges_held; e++) begin
      a = edge_end_a[e];
      b = edge_end_b[e];
      if (!tree_edge[e] && a != b) begin
        sig_hi[e] = label_hi[e];
        sig_lo[e] = label_lo[e];
        acc_hi[a] ^= label_hi[e];
        acc_lo[a] ^= label_lo[e];
        acc_hi[b] ^= label_hi[e];
        acc_lo[b] ^= label_lo[e];
      end
    end
    // reverse BFS walk pushes subtree sums up to the parents
    for (int k = int'(nodes_held) - 1; k >= 0; k--) begin
      v = visit_seq[k];
      p = node_parent[v];
      pe = node_link[v];
      if (p != v) begin
        if (pe < edges_held) begin
          sig_hi[pe] = acc_hi[v];
          sig_lo[pe] = acc_lo[v];
        end
        acc_hi[p] ^= acc_hi[v];
        acc_lo[p] ^= acc_lo[v];
      end
    end
  endfunction

  function automatic void apply_request(input xcsb_pkg::req_t r);
    xcsb_pkg::res_t res;
    case (r.req_type)
      xcsb_pkg::REQ_LOAD_NODE: begin
        if (nodes_held < xcsb_pkg::MAX_NODES) begin
          visit_seq[nodes_held] = r.node_id;
          node_parent[r.node_id] = r.parent_node;
          node_link[r.node_id] = r.link_edge;
          nodes_held++;
        end
      end
      xcsb_pkg::REQ_LOAD_EDGE: begin
        edge_end_a[r.edge_id] = r.end_a;
        edge_end_b[r.edge_id] = r.end_b;
        label_hi[r.edge_id] = r.label_high;
        label_lo[r.edge_id] = r.label_low;
        if (r.edge_id + 1 > edges_held) edges_held = r.edge_id + 1;
      end
      xcsb_pkg::REQ_COMPUTE: compute_signatures();
      xcsb_pkg::REQ_READ: begin
        res.result_edge = r.edge_id;
        res.sig_high = sig_hi[r.edge_id];
        res.sig_low = sig_lo[r.edge_id];
        res.tree_flag = tree_edge[r.edge_id];
        res.bridge_flag = tree_edge[r.edge_id] && sig_hi[r.edge_id] == '0
                          && sig_lo[r.edge_id] == '0;
        read_results = {read_results, res};
      end
      xcsb_pkg::REQ_CLEAR: begin
        nodes_held = 0;
        edges_held = 0;
        wipe_signatures();
      end
      default: ;
    endcase
  endfunction

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    nodes_held = 0;
    edges_held = 0;
    for (int v = 0; v < xcsb_pkg::MAX_NODES; v++) begin
      visit_seq[v] = '0;
      node_parent[v] = '0;
      node_link[v] = '0;
    end
    for (int e = 0; e < xcsb_pkg::MAX_EDGES; e++) begin
      edge_end_a[e] = '0;
      edge_end_b[e] = '0;
      label_hi[e] = '0;
      label_lo[e] = '0;
    end
    wipe_signatures();
  end

  assign pending_o = read_results.size();

  always @(posedge clk_i) begin
    xcsb_pkg::res_t want;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (read_results.size() == 0) begin
          report("unexpected result", {result_i.sig_high, result_i.sig_low}, '0);
        end else begin
          want = read_results.pop_front();
          if (result_i.result_edge !== want.result_edge)
            report("result_edge", 128'(result_i.result_edge), 128'(want.result_edge));
          if (result_i.sig_high !== want.sig_high)
            report("sig_high", 128'(result_i.sig_high), 128'(want.sig_high));
          if (result_i.sig_low !== want.sig_low)
            report("sig_low", 128'(result_i.sig_low), 128'(want.sig_low));
          if (result_i.tree_flag !== want.tree_flag)
            report("tree_flag", 128'(result_i.tree_flag), 128'(want.tree_flag));
          if (result_i.bridge_flag !== want.bridge_flag)
            report("bridge_flag", 128'(result_i.bridge_flag), 128'(want.bridge_flag));
        end
      end
      if (start_i && !busy_i) apply_request(req_i);
    end
  end

endmodule

// ===== tb/xor_cut_signature_bridges_unit_tb.sv =====
// Testbench top: stimulus for the cut signature bridge unit and the final verdict.
`timescale 1ns / 1ps
module xor_cut_signature_bridges_unit_tb;

  localparam int TotalItems = 2000;
  localparam int QuietTail  = 250;
  localparam int ReqW       = $bits(xcsb_pkg::req_t);

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  xcsb_pkg::req_t req_i;
  logic           result_valid_o;
  xcsb_pkg::res_t result_o;
  int             fail_count;
  int             pending;
  int             items_sent;

  xor_cut_signature_bridges_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  xcsb_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .result_valid_i(result_valid_o),
    .result_i      (result_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one transfer; start stays high into the next item unless a gap follows
  task automatic send(input xcsb_pkg::req_t r);
    if (items_sent < TotalItems - QuietTail && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  function automatic xcsb_pkg::req_t node_req(input logic [9:0] id, input logic [9:0] par,
                                              input logic [11:0] pe);
    xcsb_pkg::req_t r;
    r = '0;
    r.req_type = xcsb_pkg::REQ_LOAD_NODE;
    r.node_id = id;
    r.parent_node = par;
    r.link_edge = pe;
    r.edge_id = 12'($urandom);
    return r;
  endfunction

  function automatic xcsb_pkg::req_t edge_req(input logic [11:0] id, input logic [9:0] a,
                                              input logic [9:0] b, input logic [127:0] lbl);
    xcsb_pkg::req_t r;
    r = '0;
    r.req_type = xcsb_pkg::REQ_LOAD_EDGE;
    r.edge_id = id;
    r.end_a = a;
    r.end_b = b;
    {r.label_high, r.label_low} = lbl;
    r.node_id = 10'($urandom);
    return r;
  endfunction

  function automatic xcsb_pkg::req_t op_req(input logic [2:0] kind, input logic [11:0] id);
    xcsb_pkg::req_t r;
    r = '0;
    r.req_type = kind;
    r.edge_id = id;
    return r;
  endfunction

  function automatic logic [127:0] rand_label();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  function automatic xcsb_pkg::req_t noise_req();
    xcsb_pkg::req_t r;
    r = ReqW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.req_type = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // optional clear, a forest with mostly consistent tree edges, extra cross edges and noise, then compute and reads
  task automatic graph_phase();
    logic [9:0] ids [16];
    logic [9:0] par [16];
    int n, m;
    logic [11:0] pe;
    if ($urandom_range(0, 3) == 0) send(op_req(xcsb_pkg::REQ_CLEAR, 12'($urandom)));
    n = $urandom_range(1, 12);
    m = (n - 1) + $urandom_range(0, 6);
    for (int k = 0; k < n; k++) begin
      ids[k] = 10'($urandom);
      par[k] = (k == 0 || $urandom_range(0, 5) == 0) ? ids[k] : ids[$urandom_range(0, k - 1)];
      pe = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'(k - 1);
      send(node_req(ids[k], par[k], pe));
      if ($urandom_range(0, 9) == 0) send(noise_req());
    end
    for (int e = 0; e < m; e++) begin
      if (e < n - 1)
        send(edge_req(12'(e), ids[e + 1], par[e + 1], rand_label()));
      else if ($urandom_range(0, 7) == 0)
        send(edge_req(12'(e), ids[e % n], ids[e % n], rand_label()));
      else if ($urandom_range(0, 7) == 0)
        send(edge_req(12'(e), 10'($urandom), 10'($urandom), rand_label()));
      else
        send(edge_req(12'(e), ids[$urandom_range(0, n - 1)], ids[$urandom_range(0, n - 1)],
                      rand_label()));
      if ($urandom_range(0, 9) == 0)
        send(op_req(xcsb_pkg::REQ_READ, 12'($urandom_range(0, m))));
    end
    send(op_req(xcsb_pkg::REQ_COMPUTE, 12'($urandom)));
    for (int e = 0; e < m; e++) send(op_req(xcsb_pkg::REQ_READ, 12'(e)));
    send(op_req(xcsb_pkg::REQ_READ, 12'($urandom)));
  endtask

  initial begin
    items_sent = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, self loop, missing parent edge, repeated node, unknown codes
    send(op_req(xcsb_pkg::REQ_READ, 12'd4095));
    send(node_req(10'd0, 10'd0, 12'd4095));
    send(node_req(10'd1023, 10'd0, 12'd0));
    send(node_req(10'd7, 10'd1023, 12'd4095));
    send(node_req(10'd9, 10'd1023, 12'd3));
    send(node_req(10'd9, 10'd0, 12'd3));
    send(edge_req(12'd0, 10'd0, 10'd1023, '1));
    send(edge_req(12'd1, 10'd5, 10'd5, '1));
    send(edge_req(12'd2, 10'd1023, 10'd7, {$urandom, $urandom, $urandom, $urandom}));
    send(edge_req(12'd3, 10'd9, 10'd0, '0));
    send(edge_req(12'd4, 10'd9, 10'd7, {64'hffff_ffff_ffff_ffff, 64'd0}));
    send(op_req(xcsb_pkg::REQ_READ, 12'd0));
    send(op_req(xcsb_pkg::REQ_COMPUTE, 12'd0));
    for (int e = 0; e < 5; e++) send(op_req(xcsb_pkg::REQ_READ, 12'(e)));
    send(op_req(xcsb_pkg::REQ_READ, 12'd4095));
    send(op_req(3'd5, 12'd0));
    send(op_req(3'd6, 12'd0));
    send(op_req(3'd7, 12'd0));
    send(op_req(xcsb_pkg::REQ_CLEAR, 12'd0));
    send(op_req(xcsb_pkg::REQ_READ, 12'd0));

    // node list overflow: more loads than the list holds
    for (int k = 0; k < xcsb_pkg::MAX_NODES + 6; k++)
      send(node_req(10'($urandom), 10'($urandom), 12'($urandom_range(0, 6))));
    send(op_req(xcsb_pkg::REQ_COMPUTE, 12'd0));
    for (int e = 0; e < 6; e++) send(op_req(xcsb_pkg::REQ_READ, 12'(e)));

    while (items_sent < TotalItems) graph_phase();
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
